[hw/rtl/yaw_rate_accel_limiter_macros.svh]
// Assertion macros shared by the heading limiter checker.
`ifndef YAW_RATE_ACCEL_LIMITER_MACROS_SVH
`define YAW_RATE_ACCEL_LIMITER_MACROS_SVH

// Same-cycle implication under reset.
`define YRAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading limiter check failed");

// Next-cycle implication under reset.
`define YRAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading limiter check failed");

`endif

[hw/rtl/yral_pkg.sv]
// Shared types, constants and tables of the heading slew-rate limiter.
`timescale 1ns / 1ps

package yral_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int CORDIC_STEPS    = 16;

    // CORDIC datapath widths
    localparam int CORDIC_W = 36;
    localparam int Z_W      = 34;
    localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = PI_Q30 / 2;
    localparam longint PI_F        = (PI_Q30 + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;

    localparam logic signed [16:0] PI_Q     = 17'(PI_F);
    localparam logic signed [16:0] TWO_PI_Q = 17'(2 * PI_F);
    localparam logic signed [16:0] ANG_MIN  = -17'sd16384;
    localparam logic signed [16:0] ANG_MAX  = 17'sd16383;
    localparam logic signed [14:0] HEAD_MAX = 15'(PI_F);
    localparam logic signed [14:0] HEAD_MIN = 15'(-PI_F);

    // Shared divider widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 18;
    localparam int DIV_CW = $clog2(DIV_NW);

    // Configuration register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_RATE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_ACCEL_LIMIT = 2'd1;
    localparam logic [1:0] REG_MIN_DIST_SQ = 2'd2;

    localparam logic [14:0] RATE_LIMIT_RST  = 15'd25736;
    localparam logic [16:0] ACCEL_LIMIT_RST = 17'd64340;
    localparam logic [31:0] MIN_DIST_RST    = 32'd167772;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CORDIC,
        ST_TARGET,
        ST_ERR,
        ST_MUL_AT,
        ST_MUL_LD,
        ST_MUL_A,
        ST_FIN_A,
        ST_MUL_WW,
        ST_MUL_DW,
        ST_DIV_B,
        ST_CLAMP,
        ST_DIV_R,
        ST_DONE
    } yral_state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Truncated atan(2^-i) in Q.30
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:  val = 34'sd843314856;
            5'd1:  val = 34'sd497837829;
            5'd2:  val = 34'sd263043836;
            5'd3:  val = 34'sd133525158;
            5'd4:  val = 34'sd67021686;
            5'd5:  val = 34'sd33543515;
            5'd6:  val = 34'sd16775850;
            5'd7:  val = 34'sd8388437;
            5'd8:  val = 34'sd4194282;
            5'd9:  val = 34'sd2097149;
            5'd10: val = 34'sd1048575;
            5'd11: val = 34'sd524287;
            5'd12: val = 34'sd262143;
            5'd13: val = 34'sd131071;
            5'd14: val = 34'sd65535;
            5'd15: val = 34'sd32767;
            5'd16: val = 34'sd16383;
            5'd17: val = 34'sd8191;
            5'd18: val = 34'sd4095;
            5'd19: val = 34'sd2047;
            5'd20: val = 34'sd1023;
            5'd21: val = 34'sd511;
            5'd22: val = 34'sd255;
            5'd23: val = 34'sd127;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/yral_divider.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module yral_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  yral_pkg::div_ctl_t               ctl,
    input  logic [yral_pkg::DIV_NW-1:0]      dividend,
    input  logic [yral_pkg::DIV_DW-1:0]      divisor,
    output yral_pkg::div_stat_t              stat,
    output logic [yral_pkg::DIV_NW-1:0]      quotient
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [yral_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [yral_pkg::DIV_NW-1:0]  num_reg, num_next;
    logic [yral_pkg::DIV_DW-1:0]  rem_reg, rem_next;
    logic [yral_pkg::DIV_DW-1:0]  den_reg, den_next;
    logic [yral_pkg::DIV_DW:0]    rem_sh;
    logic [yral_pkg::DIV_DW:0]    rem_sub;

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, num_reg[yral_pkg::DIV_NW-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[yral_pkg::DIV_DW-1:0];
                num_next = {num_reg[yral_pkg::DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[yral_pkg::DIV_DW-1:0];
                num_next = {num_reg[yral_pkg::DIV_NW-2:0], 1'b0};
            end
            if (cnt_reg == yral_pkg::DIV_CW'(yral_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + yral_pkg::DIV_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;

endmodule

[hw/rtl/yaw_rate_accel_limiter.sv]
// Heading slew-rate limiter: top level with sequencer, datapath and register port.
`timescale 1ns / 1ps

// Takes one look-ahead vector at a time: in_ready is high only while the
// sequencer is idle. An item passes through the squaring of its three
// components on the shared multiplier, 16 CORDIC iterations, the multiply
// states and one pass through the shared 48-bit divider (one quotient bit a
// cycle) when the step bound follows the acceleration parabola, or two
// passes when it saturates at the rate limit. A finished result waits in
// the output register, so the next item can be taken before the result is
// read. Registers sit at byte addresses 0 (rate_limit), 4 (accel_limit) and
// 8 (min_distance_sq), read back as written in their implemented bits, and
// must only be written while no item is in flight.

module yaw_rate_accel_limiter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] dir_x,
    input  logic signed [23:0] dir_y,
    input  logic signed [23:0] dir_z,
    input  logic [15:0]        dt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] heading,
    output logic signed [15:0] heading_rate,
    output logic signed [14:0] raw_target
);

    yral_pkg::yral_state_t state_reg, state_next;

    // Configuration
    logic [14:0] rate_limit_reg;
    logic [16:0] accel_limit_reg;
    logic [31:0] min_dist_reg;
    logic        cfg_wr;

    // Item and datapath registers
    logic [4:0]                           cnt_reg, cnt_next;
    logic signed [23:0]                   dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [15:0]                          dt_reg, dt_next;
    logic signed [yral_pkg::CORDIC_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [yral_pkg::Z_W-1:0]      cz_reg, cz_next;
    logic [48:0]                          mag_reg, mag_next;
    logic signed [16:0]                   target_reg, target_next;
    logic signed [16:0]                   d_reg, d_next;
    logic                                 neg_reg, neg_next;
    logic signed [34:0]                   at_reg, at_next;
    logic signed [32:0]                   ld_reg, ld_next;
    logic signed [17:0]                   w_reg, w_next;
    logic [31:0]                          ww_reg, ww_next;
    logic signed [34:0]                   dw_reg, dw_next;
    logic signed [51:0]                   prod_reg, prod_next;
    logic signed [49:0]                   dmax_reg, dmax_next;
    logic signed [15:0]                   last_h_reg, last_h_next;
    logic signed [15:0]                   last_r_reg, last_r_next;

    // Output register
    logic                                 out_valid_reg, out_valid_next;
    logic signed [14:0]                   heading_reg, heading_next;
    logic signed [15:0]                   rate_reg, rate_next;
    logic signed [14:0]                   raw_reg, raw_next;

    // Shared multiplier
    logic signed [35:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [60:0] mul_p;

    // Divider hookup
    yral_pkg::div_ctl_t               div_ctl;
    yral_pkg::div_stat_t              div_stat;
    logic [yral_pkg::DIV_NW-1:0]      div_num;
    logic [yral_pkg::DIV_DW-1:0]      div_den;
    logic [yral_pkg::DIV_NW-1:0]      div_q;

    // Combinational helpers
    logic [16:0]        al_eff;
    logic signed [17:0] yddm;
    logic signed [15:0] ydm;
    logic signed [35:0] v_sum;
    logic [35:0]        v_abs;
    logic               case_a;
    logic               in_acc;
    logic               out_free;
    logic               cordic_last;

    assign in_acc      = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign cordic_last = (cnt_reg == 5'(yral_pkg::CORDIC_STEPS - 1));
    assign al_eff      = (accel_limit_reg == '0) ? 17'd1 : accel_limit_reg;
    assign yddm        = neg_reg ? -$signed({1'b0, al_eff}) : $signed({1'b0, al_eff});
    assign ydm         = neg_reg ? -$signed({1'b0, rate_limit_reg})
                                 : $signed({1'b0, rate_limit_reg});
    assign v_sum       = 36'(last_r_reg) * 36'sd65536 + 36'(at_reg);
    assign v_abs       = v_sum[35] ? 36'(-v_sum) : 36'(v_sum);
    assign case_a      = v_abs <= {5'b0, rate_limit_reg, 16'b0};

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            yral_pkg::REG_RATE_LIMIT:  prdata = {17'b0, rate_limit_reg};
            yral_pkg::REG_ACCEL_LIMIT: prdata = {15'b0, accel_limit_reg};
            yral_pkg::REG_MIN_DIST_SQ: prdata = min_dist_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg  <= yral_pkg::RATE_LIMIT_RST;
            accel_limit_reg <= yral_pkg::ACCEL_LIMIT_RST;
            min_dist_reg    <= yral_pkg::MIN_DIST_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                yral_pkg::REG_RATE_LIMIT:  rate_limit_reg  <= pwdata[14:0];
                yral_pkg::REG_ACCEL_LIMIT: accel_limit_reg <= pwdata[16:0];
                yral_pkg::REG_MIN_DIST_SQ: min_dist_reg    <= pwdata;
                default:                   ;
            endcase
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            yral_pkg::ST_SQ:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = 36'(dx_reg); mul_b = 25'(dx_reg); end
                    2'd1:    begin mul_a = 36'(dy_reg); mul_b = 25'(dy_reg); end
                    default: begin mul_a = 36'(dz_reg); mul_b = 25'(dz_reg); end
                endcase
            end
            yral_pkg::ST_MUL_AT: begin mul_a = $signed({20'b0, dt_reg}); mul_b = 25'(yddm); end
            yral_pkg::ST_MUL_LD: begin mul_a = 36'(last_r_reg); mul_b = $signed({9'b0, dt_reg}); end
            yral_pkg::ST_MUL_A:  begin mul_a = 36'(at_reg); mul_b = $signed({9'b0, dt_reg}); end
            yral_pkg::ST_MUL_WW: begin mul_a = 36'(w_reg); mul_b = 25'(w_reg); end
            yral_pkg::ST_MUL_DW: begin mul_a = 36'(w_reg); mul_b = $signed({9'b0, dt_reg}); end
            default:             ;
        endcase
    end

    assign mul_p = 61'(mul_a) * 61'(mul_b);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            yral_pkg::ST_IDLE:   if (in_acc) state_next = yral_pkg::ST_SQ;
            yral_pkg::ST_SQ:     if (cnt_reg == 5'd2) state_next = yral_pkg::ST_CORDIC;
            yral_pkg::ST_CORDIC: if (cordic_last) state_next = yral_pkg::ST_TARGET;
            yral_pkg::ST_TARGET: state_next = yral_pkg::ST_ERR;
            yral_pkg::ST_ERR:    state_next = yral_pkg::ST_MUL_AT;
            yral_pkg::ST_MUL_AT: state_next = yral_pkg::ST_MUL_LD;
            yral_pkg::ST_MUL_LD: state_next = case_a ? yral_pkg::ST_MUL_A : yral_pkg::ST_MUL_WW;
            yral_pkg::ST_MUL_A:  state_next = yral_pkg::ST_FIN_A;
            yral_pkg::ST_FIN_A:  state_next = yral_pkg::ST_CLAMP;
            yral_pkg::ST_MUL_WW: state_next = yral_pkg::ST_MUL_DW;
            yral_pkg::ST_MUL_DW: state_next = yral_pkg::ST_DIV_B;
            yral_pkg::ST_DIV_B:  if (div_stat.done) state_next = yral_pkg::ST_CLAMP;
            yral_pkg::ST_CLAMP:  state_next = yral_pkg::ST_DIV_R;
            yral_pkg::ST_DIV_R:  if (div_stat.done) state_next = yral_pkg::ST_DONE;
            yral_pkg::ST_DONE:   if (out_free) state_next = yral_pkg::ST_IDLE;
            default:             state_next = yral_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        logic signed [23:0]                   sel_x, sel_y;
        logic signed [yral_pkg::CORDIC_W-1:0] xe, ye, xs, ys;
        logic signed [yral_pkg::Z_W-1:0]      zs, zr;
        logic signed [17:0]                   de, he;
        logic signed [51:0]                   pa;
        logic signed [49:0]                   qs, dq, dmax_abs;
        logic [16:0]                          absd, absd_new;
        logic signed [16:0]                   dnew;
        logic signed [32:0]                   rq;

        cnt_next       = cnt_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        dt_next        = dt_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        mag_next       = mag_reg;
        target_next    = target_reg;
        d_next         = d_reg;
        neg_next       = neg_reg;
        at_next        = at_reg;
        ld_next        = ld_reg;
        w_next         = w_reg;
        ww_next        = ww_reg;
        dw_next        = dw_reg;
        prod_next      = prod_reg;
        dmax_next      = dmax_reg;
        last_h_next    = last_h_reg;
        last_r_next    = last_r_reg;
        heading_next   = heading_reg;
        rate_next      = rate_reg;
        raw_next       = raw_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_ctl.start  = 1'b0;
        div_num        = '0;
        div_den        = '0;

        sel_x    = dir_x;
        sel_y    = dir_y;
        xe       = yral_pkg::CORDIC_W'(sel_x) <<< 8;
        ye       = yral_pkg::CORDIC_W'(sel_y) <<< 8;
        xs       = cx_reg >>> cnt_reg;
        ys       = cy_reg >>> cnt_reg;
        zs       = cz_reg + yral_pkg::Z_W'(64'sd1 <<< (yral_pkg::RND_SHIFT - 1));
        zr       = zs >>> yral_pkg::RND_SHIFT;
        de       = 18'(target_reg) - 18'(last_h_reg);
        he       = 18'(last_h_reg) + 18'(d_reg);
        pa       = prod_reg + (prod_reg[51] ? 52'sd131071 : 52'sd0);
        qs       = 50'(div_q);
        dq       = (dmax_reg + (dmax_reg[49] ? 50'sd65535 : 50'sd0)) >>> 16;
        dmax_abs = dmax_reg[49] ? -dmax_reg : dmax_reg;
        absd     = d_reg[16] ? 17'(-d_reg) : 17'(d_reg);
        dnew     = d_reg;
        absd_new = absd;
        rq       = d_reg[16] ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});

        case (state_reg)
            yral_pkg::ST_IDLE:
            begin
                // Latch the item and pre-rotate the left half-plane
                if (in_acc)
                begin
                    dx_next  = dir_x;
                    dy_next  = dir_y;
                    dz_next  = dir_z;
                    dt_next  = (dt == '0) ? 16'd1 : dt;
                    cnt_next = '0;
                    mag_next = '0;
                    cx_next  = xe;
                    cy_next  = ye;
                    cz_next  = '0;
                    if (xe < 0)
                    begin
                        if (ye >= 0)
                        begin
                            cx_next = ye;
                            cy_next = -xe;
                            cz_next = yral_pkg::Z_W'(yral_pkg::HALF_PI_Q30);
                        end
                        else
                        begin
                            cx_next = -ye;
                            cy_next = xe;
                            cz_next = yral_pkg::Z_W'(-yral_pkg::HALF_PI_Q30);
                        end
                    end
                end
            end
            yral_pkg::ST_SQ:
            begin
                // Accumulate the squared length
                mag_next = mag_reg + {1'b0, mul_p[47:0]};
                cnt_next = (cnt_reg == 5'd2) ? 5'd0 : cnt_reg + 5'd1;
            end
            yral_pkg::ST_CORDIC:
            begin
                // One vectoring micro-rotation
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + yral_pkg::atan_q30(cnt_reg);
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - yral_pkg::atan_q30(cnt_reg);
                end
                cnt_next = cordic_last ? 5'd0 : cnt_reg + 5'd1;
            end
            yral_pkg::ST_TARGET:
            begin
                // Pick the atan2 angle, zero, or hold the last heading
                if (mag_reg > {17'b0, min_dist_reg})
                begin
                    if (dx_reg == '0 && dy_reg == '0)
                        target_next = '0;
                    else if (zr > yral_pkg::Z_W'(yral_pkg::PI_Q))
                        target_next = yral_pkg::PI_Q;
                    else if (zr < -yral_pkg::Z_W'(yral_pkg::PI_Q))
                        target_next = -yral_pkg::PI_Q;
                    else
                        target_next = 17'(zr);
                    if (target_next > yral_pkg::ANG_MAX)
                        target_next = yral_pkg::ANG_MAX;
                    if (target_next < yral_pkg::ANG_MIN)
                        target_next = yral_pkg::ANG_MIN;
                end
                else
                begin
                    target_next = 17'(last_h_reg);
                end
            end
            yral_pkg::ST_ERR:
            begin
                // Wrap the error once into (-pi, pi)
                if (de >= 18'(yral_pkg::PI_Q))
                    de = de - 18'(yral_pkg::TWO_PI_Q);
                if (de <= -18'(yral_pkg::PI_Q))
                    de = de + 18'(yral_pkg::TWO_PI_Q);
                d_next   = 17'(de);
                neg_next = de[17];
            end
            yral_pkg::ST_MUL_AT:
            begin
                at_next = mul_p[34:0];
                w_next  = 18'(ydm) - 18'(last_r_reg);
            end
            yral_pkg::ST_MUL_LD:
            begin
                ld_next = mul_p[32:0];
            end
            yral_pkg::ST_MUL_A:
            begin
                prod_next = mul_p[51:0];
            end
            yral_pkg::ST_FIN_A:
            begin
                // Parabolic bound: rate*dt + a*dt^2/2
                pa        = pa >>> 17;
                dmax_next = 50'(ld_reg) + pa[49:0];
            end
            yral_pkg::ST_MUL_WW:
            begin
                ww_next = mul_p[31:0];
            end
            yral_pkg::ST_MUL_DW:
            begin
                // Start w^2 / (2a)
                dw_next       = mul_p[34:0];
                div_ctl.start = 1'b1;
                div_num       = {ww_reg, 16'b0};
                div_den       = {al_eff, 1'b0};
            end
            yral_pkg::ST_DIV_B:
            begin
                if (div_stat.done)
                    dmax_next = neg_reg ? 50'(dw_reg) + qs : 50'(dw_reg) - qs;
            end
            yral_pkg::ST_CLAMP:
            begin
                // Clamp the error and start error / dt
                if (50'({absd, 16'b0}) > dmax_abs)
                begin
                    dnew     = dq[16:0];
                    absd_new = dnew[16] ? 17'(-dnew) : 17'(dnew);
                end
                d_next        = dnew;
                div_ctl.start = 1'b1;
                div_num       = {15'b0, absd_new, 16'b0};
                div_den       = {2'b0, dt_reg};
            end
            yral_pkg::ST_DIV_R:
            begin
                // Saturate the rate, step and wrap the heading
                if (div_stat.done)
                begin
                    if (rq > 33'sd32767)
                        last_r_next = 16'sh7fff;
                    else if (rq < -33'sd32768)
                        last_r_next = -16'sd32768;
                    else
                        last_r_next = 16'(rq);
                    if (he > 18'(yral_pkg::PI_Q))
                        he = he - 18'(yral_pkg::TWO_PI_Q);
                    if (he < -18'(yral_pkg::PI_Q))
                        he = he + 18'(yral_pkg::TWO_PI_Q);
                    if (he > 18'(yral_pkg::ANG_MAX))
                        he = 18'(yral_pkg::ANG_MAX);
                    if (he < 18'(yral_pkg::ANG_MIN))
                        he = 18'(yral_pkg::ANG_MIN);
                    last_h_next = 16'(he);
                end
            end
            yral_pkg::ST_DONE:
            begin
                // Hand the item to the output register
                if (out_free)
                begin
                    heading_next   = last_h_reg[14:0];
                    rate_next      = last_r_reg;
                    raw_next       = target_reg[14:0];
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    yral_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= yral_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_h_reg    <= '0;
            last_r_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            last_h_reg    <= last_h_next;
            last_r_reg    <= last_r_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        dt_reg      <= dt_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        mag_reg     <= mag_next;
        target_reg  <= target_next;
        d_reg       <= d_next;
        neg_reg     <= neg_next;
        at_reg      <= at_next;
        ld_reg      <= ld_next;
        w_reg       <= w_next;
        ww_reg      <= ww_next;
        dw_reg      <= dw_next;
        prod_reg    <= prod_next;
        dmax_reg    <= dmax_next;
        heading_reg <= heading_next;
        rate_reg    <= rate_next;
        raw_reg     <= raw_next;
    end

    assign in_ready     = (state_reg == yral_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign heading      = heading_reg;
    assign heading_rate = rate_reg;
    assign raw_target   = raw_reg;

endmodule

[hw/rtl/yral_checker.sv]
// Port-level checks of the heading limiter, bound to the top level.
`timescale 1ns / 1ps
`include "yaw_rate_accel_limiter_macros.svh"

module yral_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [14:0] heading,
    input logic signed [15:0] heading_rate,
    input logic signed [14:0] raw_target
);

    // One item in flight: ready drops after an accept
    `YRAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // Heading stays wrapped to plus or minus pi
    `YRAL_ASSERT_NOW(a_heading_range, clk, rst_n, out_valid, heading <= yral_pkg::HEAD_MAX && heading >= yral_pkg::HEAD_MIN)

    // Raw target stays within plus or minus pi
    `YRAL_ASSERT_NOW(a_target_range, clk, rst_n, out_valid, raw_target <= yral_pkg::HEAD_MAX && raw_target >= yral_pkg::HEAD_MIN)

    // A stalled result holds
    `YRAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(heading) && $stable(heading_rate))

endmodule

bind yaw_rate_accel_limiter yral_checker u_yral_checker (.*);
